FILE: hdl/aabt_pkg.sv
// Shared types and constants for the angle alpha-beta tracker.
// Holds the angle width, register codes, reset values and the
// controller-to-datapath command and status structs.
`timescale 1ns / 1ps

package aabt_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int ANG_SHIFT  = 32 - ANGLE_BITS;

    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ALPHA_GAIN  = 2'd0;
    localparam t_cfg_idx CFG_BETA_GAIN   = 2'd1;
    localparam t_cfg_idx CFG_SPEED_SCALE = 2'd2;

    localparam logic [15:0] ALPHA_RESET = 16'd6554;
    localparam logic [15:0] BETA_RESET  = 16'd328;
    localparam logic [31:0] SCALE_RESET = 32'd65536;

    typedef struct packed {
        logic accept;
        logic mul_alpha;
        logic mul_beta;
        logic upd_speed;
        logic mul_scale;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic started;
    } t_status;

endpackage

FILE: hdl/angle_alpha_beta_tracker_core.sv
// Angle alpha-beta tracker, top level: controller plus datapath.
// Steps: alpha multiply, beta multiply, speed update, scale multiply, done;
// a seed goes straight to done. Input stalls until the result is loaded,
// since one shared multiplier serves alpha, beta and speed scaling in turn.
// Reset (i_rst_n low, synchronous): gains to defaults, state cleared,
// the next sample seeds the tracker. A write to a defined config register also forces a seed.
`timescale 1ns / 1ps

module angle_alpha_beta_tracker_core
    import aabt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ANGLE_BITS-1:0] i_measured_angle,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [31:0]    o_speed_out,
    output logic [ANGLE_BITS-1:0] o_angle_out,
    output logic                  o_seeded
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    aabt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    aabt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_measured_angle (i_measured_angle),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_speed_out      (o_speed_out),
        .o_angle_out      (o_angle_out),
        .o_seeded         (o_seeded)
    );

endmodule

FILE: hdl/aabt_ctrl.sv
// Sequencing controller for the tracker: handshakes and step order.
// Depends on aabt_pkg for the command and status structs.
`timescale 1ns / 1ps

module aabt_ctrl
    import aabt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MULA  = 6'b000010,
        S_MULB  = 6'b000100,
        S_SPD   = 6'b001000,
        S_MULS  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.mul_alpha = (r_state == S_MULA);
        o_cmd.mul_beta  = (r_state == S_MULB);
        o_cmd.upd_speed = (r_state == S_SPD);
        o_cmd.mul_scale = (r_state == S_MULS);
        o_cmd.out_load  = out_load;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.started ? S_MULA : S_DONE;
                end
            end
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_SPD;
            S_SPD:   n_state = S_MULS;
            S_MULS:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/aabt_dp.sv
// Tracker datapath: config registers, angle and speed state, shared
// multiplier, rounding, saturation and the output register.
// Depends on aabt_pkg for widths, register codes and the command struct.
`timescale 1ns / 1ps

module aabt_dp
    import aabt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  t_cfg_idx              i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [ANGLE_BITS-1:0] i_measured_angle,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic signed [31:0]    o_speed_out,
    output logic [ANGLE_BITS-1:0] o_angle_out,
    output logic                  o_seeded
);

    logic [15:0]        r_alpha;
    logic [15:0]        r_beta;
    logic [31:0]        r_scale;
    logic [31:0]        r_angle;
    logic signed [31:0] r_speed;
    logic               r_started;
    logic               r_seed;
    logic [31:0]        r_pred;
    logic signed [31:0] r_err;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_speed_out;
    logic [ANGLE_BITS-1:0] r_angle_out;
    logic               r_seeded;

    logic [31:0]        meas;
    logic [31:0]        pred;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] rnd;
    logic signed [33:0] spd_sum;
    logic signed [31:0] spd_sat;
    logic signed [31:0] out_sat;
    logic               cfg_hit;

    assign meas = {i_measured_angle, {ANG_SHIFT{1'b0}}};
    assign pred = r_angle + r_speed;

    always_comb begin
        mul_a = {17'd0, r_alpha};
        mul_b = {r_err[31], r_err};
        if (i_cmd.mul_beta) begin
            mul_a = {17'd0, r_beta};
        end else if (i_cmd.mul_scale) begin
            mul_a = {r_speed[31], r_speed};
            mul_b = {1'b0, r_scale};
        end
    end

    assign mul_p = mul_a * mul_b;
    assign rnd   = (r_prod + 64'sd32768) >>> 16;

    assign spd_sum = {{2{r_speed[31]}}, r_speed} + rnd[33:0];
    always_comb begin
        if (spd_sum[33:31] == 3'b000 || spd_sum[33:31] == 3'b111) begin
            spd_sat = spd_sum[31:0];
        end else begin
            spd_sat = spd_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_comb begin
        if ((&rnd[63:31]) || !(|rnd[63:31])) begin
            out_sat = rnd[31:0];
        end else begin
            out_sat = rnd[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_ALPHA_GAIN ||
                                     i_cfg_index == CFG_BETA_GAIN ||
                                     i_cfg_index == CFG_SPEED_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_RESET;
            r_beta    <= BETA_RESET;
            r_scale   <= SCALE_RESET;
            r_angle   <= '0;
            r_speed   <= '0;
            r_started <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ALPHA_GAIN:  r_alpha <= i_cfg_data[15:0];
                    CFG_BETA_GAIN:   r_beta  <= i_cfg_data[15:0];
                    CFG_SPEED_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_started <= 1'b0;
            end else if (i_cmd.accept) begin
                r_started <= 1'b1;
            end
            if (i_cmd.accept && !r_started) begin
                r_angle <= meas;
                r_speed <= '0;
            end
            if (i_cmd.mul_beta) begin
                r_angle <= r_pred + rnd[31:0];
            end
            if (i_cmd.upd_speed) begin
                r_speed <= spd_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seed <= !r_started;
            r_pred <= pred;
            r_err  <= meas - pred;
        end
        if (i_cmd.mul_alpha || i_cmd.mul_beta || i_cmd.mul_scale) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.out_load) begin
            r_speed_out <= r_seed ? 32'sd0 : out_sat;
            r_angle_out <= r_angle[31 -: ANGLE_BITS];
            r_seeded    <= r_seed;
        end
    end

    assign o_status.started = r_started;
    assign o_speed_out      = r_speed_out;
    assign o_angle_out      = r_angle_out;
    assign o_seeded         = r_seeded;

endmodule

FILE: hdl/aabt_checker.sv
// Port-level checks for the angle alpha-beta tracker, bound to the top level.
// Depends on aabt_pkg for port widths.
`timescale 1ns / 1ps

module aabt_checker
    import aabt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic signed [31:0]    o_speed_out,
    input logic [ANGLE_BITS-1:0] o_angle_out,
    input logic                  o_seeded
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_speed_out) &&
        $stable(o_angle_out) && $stable(o_seeded))
        else $error("stalled result changed");

    a_seed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_seeded |-> o_speed_out == 32'sd0)
        else $error("seeding result carries nonzero speed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the sample was processed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshake state");

endmodule

bind angle_alpha_beta_tracker_core aabt_checker u_aabt_checker (.*);
